// File: design/mf3_pkg.sv
// shared types and constants for the 3x3 median filter
package mf3_pkg;

  localparam int PIXEL_BITS  = 16;
  localparam int POS_BITS    = 11;
  localparam int DIM_BITS    = 12;
  localparam int WIN_TAPS    = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [DIM_BITS-1:0] DIM_MIN      = 12'd3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t pixel_value;
    logic   frame_start;
  } in_item_t;

  typedef struct packed {
    pixel_t              filtered_value;
    logic [POS_BITS-1:0] out_row;
    logic [POS_BITS-1:0] out_col;
    logic                frame_end;
  } out_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                frame_end;
  } tag_t;

  typedef struct packed {
    pixel_t [WIN_TAPS-1:0] win;
    tag_t                  tag;
  } job_t;

endpackage

// File: design/mf3_front.sv
// front end: position counters, line stores, window and job classification
module mf3_front import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  cfg_reg_t            cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  input  logic [CNT_BITS-1:0] q_count,
  output logic                push_valid,
  output job_t                push_job
);

  localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] frame_height;
  logic [DIM_BITS-1:0] w_eff;
  logic [DIM_BITS-1:0] h_eff;

  logic [POS_BITS-1:0] row_count;
  logic [POS_BITS-1:0] col_count;
  logic [POS_BITS-1:0] r_cur;
  logic [POS_BITS-1:0] c_cur;
  logic [POS_BITS-1:0] row_next;
  logic [POS_BITS-1:0] col_next;
  logic [DIM_BITS-1:0] c_inc;
  logic [DIM_BITS-1:0] r_inc;
  logic [31:0]         idx_full;
  logic [ADDR_BITS-1:0] rd_idx;
  logic                accept;
  logic                fwd;

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t lower_mem [MAX_WIDTH];
  pixel_t up_rd;
  pixel_t lo_rd;
  pixel_t up_eff;
  pixel_t lo_eff;

  logic                 s1_valid;
  pixel_t               s1_pix;
  logic [ADDR_BITS-1:0] s1_idx;
  logic                 s1_emit;
  logic                 s1_med;
  tag_t                 s1_tag;
  logic                 s1_fwd;
  pixel_t               s1_fwd_up;
  pixel_t               s1_fwd_lo;

  pixel_t [WIN_TAPS-1:0] win;
  pixel_t [WIN_TAPS-1:0] win_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (frame_width < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = DIM_BITS'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = DIM_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // room for the item in flight plus this one
  assign in_stall = ((CNT_BITS+1)'(q_count) + (CNT_BITS+1)'(s1_valid))
                    >= (CNT_BITS+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    r_cur = in_data.frame_start ? '0 : row_count;
    c_cur = in_data.frame_start ? '0 : col_count;
    c_inc = {1'b0, c_cur} + DIM_BITS'(1);
    r_inc = {1'b0, r_cur} + DIM_BITS'(1);
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[POS_BITS-1:0];
    end else begin
      col_next = c_inc[POS_BITS-1:0];
      row_next = r_cur;
    end
    idx_full = (32'(c_cur) >= MAX_WIDTH) ? 32'(MAX_WIDTH - 1) : 32'(c_cur);
    rd_idx   = idx_full[ADDR_BITS-1:0];
    fwd      = s1_valid && (rd_idx == s1_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_next;
      col_count <= col_next;
    end
  end

  // line stores, write from stage 1, read on accept
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      upper_mem[s1_idx] <= lo_eff;
      lower_mem[s1_idx] <= s1_pix;
    end
    if (accept) begin
      up_rd <= upper_mem[rd_idx];
      lo_rd <= lower_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix        <= in_data.pixel_value;
      s1_idx        <= rd_idx;
      s1_emit       <= (r_cur != '0) && (c_cur != '0);
      s1_med        <= (r_cur >= POS_BITS'(2)) && (c_cur >= POS_BITS'(2));
      s1_tag.row    <= r_cur - POS_BITS'(1);
      s1_tag.col    <= c_cur - POS_BITS'(1);
      s1_tag.frame_end <= (r_inc == h_eff) && (c_inc == w_eff);
      s1_fwd        <= fwd;
      s1_fwd_up     <= lo_eff;
      s1_fwd_lo     <= s1_pix;
    end
  end

  // stage 1: resolve column, shift window, hand job to the queue
  always_comb begin
    up_eff      = s1_fwd ? s1_fwd_up : up_rd;
    lo_eff      = s1_fwd ? s1_fwd_lo : lo_rd;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = up_eff;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = lo_eff;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // border results are a median of zeros
  assign push_valid   = s1_valid && s1_emit;
  assign push_job.win = s1_med ? win_next : '0;
  assign push_job.tag = s1_tag;

endmodule

// File: design/mf3_queue.sv
// short job queue between front end and median pipeline
module mf3_queue import mf3_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  job_t                push_job,
  input  logic                pop,
  output logic                head_valid,
  output job_t                head_job,
  output logic [CNT_BITS-1:0] count
);

  job_t                q_mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  assign head_valid = (count != '0);
  assign head_job   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push_valid, pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/mf3_median.sv
// median-of-nine pipeline with output register
module mf3_median import mf3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  function automatic pixel_t pmin(input pixel_t a, input pixel_t b);
    pmin = (a < b) ? a : b;
  endfunction

  function automatic pixel_t pmax(input pixel_t a, input pixel_t b);
    pmax = (a < b) ? b : a;
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    med3 = pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

  pixel_t [2:0][2:0] s1_rows;
  pixel_t [2:0][2:0] p1_rows;
  pixel_t [2:0][2:0] s2_rows;
  pixel_t [2:0][2:0] p2_rows;
  pixel_t [2:0]      s3_cand;
  pixel_t [2:0]      p3_cand;
  pixel_t            x1;
  tag_t              p1_tag;
  tag_t              p2_tag;
  tag_t              p3_tag;
  logic              p1_v;
  logic              p2_v;
  logic              p3_v;
  logic              p1_ready;
  logic              p2_ready;
  logic              p3_ready;
  logic              out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign p3_ready  = !p3_v || out_ready;
  assign p2_ready  = !p2_v || p3_ready;
  assign p1_ready  = !p1_v || p2_ready;
  assign pop       = head_valid && p1_ready;

  // first two exchanges of each row; largest lands in slot 2
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_rows[k][0] = pmin(head_job.win[3*k], head_job.win[3*k+1]);
      x1            = pmax(head_job.win[3*k], head_job.win[3*k+1]);
      s1_rows[k][1] = pmin(x1, head_job.win[3*k+2]);
      s1_rows[k][2] = pmax(x1, head_job.win[3*k+2]);
    end
  end

  // last exchange, rows now sorted low to high
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_rows[k][0] = pmin(p1_rows[k][0], p1_rows[k][1]);
      s2_rows[k][1] = pmax(p1_rows[k][0], p1_rows[k][1]);
      s2_rows[k][2] = p1_rows[k][2];
    end
  end

  // max of lows, median of mids, min of highs
  always_comb begin
    s3_cand[0] = pmax(pmax(p2_rows[0][0], p2_rows[1][0]), p2_rows[2][0]);
    s3_cand[1] = med3(p2_rows[0][1], p2_rows[1][1], p2_rows[2][1]);
    s3_cand[2] = pmin(pmin(p2_rows[0][2], p2_rows[1][2]), p2_rows[2][2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p1_ready) begin
        p1_v <= head_valid;
      end
      if (p2_ready) begin
        p2_v <= p1_v;
      end
      if (p3_ready) begin
        p3_v <= p2_v;
      end
      if (out_ready) begin
        out_valid <= p3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_rows <= s1_rows;
      p1_tag  <= head_job.tag;
    end
    if (p2_ready && p1_v) begin
      p2_rows <= s2_rows;
      p2_tag  <= p1_tag;
    end
    if (p3_ready && p2_v) begin
      p3_cand <= s3_cand;
      p3_tag  <= p2_tag;
    end
    if (out_ready && p3_v) begin
      out_data.filtered_value <= med3(p3_cand[0], p3_cand[1], p3_cand[2]);
      out_data.out_row        <= p3_tag.row;
      out_data.out_col        <= p3_tag.col;
      out_data.frame_end      <= p3_tag.frame_end;
    end
  end

endmodule

// File: design/median_filter_3x3_unit.sv
// top level of the streaming 3x3 median filter
// Streaming 3x3 median filter. Pixels enter in raster order, one request per
// clock while in_stall is low; the pixel at row r, column c (both at least 1)
// yields the result for position (r-1, c-1), which is the median of its 3x3
// neighborhood, or zero on the top row and left column. The last row and
// column give no result. Throughput is one pixel per cycle while not stalled,
// set by the single read port and single write port of each line store, which
// are used once per pixel. The line store read happens on the edge that
// accepts a pixel, the window stage writes the job queue on the next, and the
// job then passes three compare stages of the median network and the output
// register. The four-entry job queue lets the output stall on its own; the
// input stalls only once the queue plus the job being formed in the window
// stage fill those four entries.
// frame_width and frame_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT
// and should be written only while the filter is idle. Line stores are not
// cleared after reset; every entry a result can use is written first.
module median_filter_3x3_unit import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_write,
  input  cfg_reg_t            cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data,
  // pixel requests
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  // filtered results
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  // front end to queue
  logic                push_valid;
  job_t                push_job;
  // queue to median pipeline
  logic                head_valid;
  job_t                head_job;
  logic                pop;
  logic [CNT_BITS-1:0] q_count;

  // counters, line stores and window; classifies each pixel
  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  // decouples the front end from output stalls
  mf3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (q_count)
  );

  // sorting network and output register
  mf3_median u_median (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: design/mf3_checker.sv
// port-level checks for the median filter, bound to the top level
module mf3_checker import mf3_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // top row and left column are zero
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_row == '0 || out_data.out_col == '0)
      |-> out_data.filtered_value == '0)
    else $error("border result not zero");

  // frame end never falls on a border position
  a_end_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end
      |-> out_data.out_row != '0 && out_data.out_col != '0)
    else $error("frame end on border position");

  // nothing pending and no stall right after reset
  a_reset_clean: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("state left over after reset");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/median_filter_3x3_unit_checker.sv
// result checker for the 3x3 median filter: predicts each result and compares it
`timescale 1ns / 1ps

module median_filter_3x3_unit_checker import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  cfg_reg_t            cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  output int                  fail_count,
  output int                  results_pending
);

  // own copy of the filter state
  pixel_t              row_above2 [MAX_WIDTH];
  pixel_t              row_above1 [MAX_WIDTH];
  pixel_t              window     [WIN_TAPS];
  int unsigned         row_pos;
  int unsigned         col_pos;
  logic [DIM_BITS-1:0] width_cfg;
  logic [DIM_BITS-1:0] height_cfg;

  out_item_t medians_due [$];
  out_item_t due;
  logic      bad;

  function automatic int unsigned clamp_dim(input logic [DIM_BITS-1:0] v,
                                            input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // insertion sort, then the middle one of nine
  function automatic pixel_t median_of_nine(input pixel_t taps [WIN_TAPS]);
    pixel_t sorted [WIN_TAPS];
    pixel_t key;
    int     j;
    sorted = taps;
    for (int i = 1; i < WIN_TAPS; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    return sorted[WIN_TAPS / 2];
  endfunction

  task automatic filter_pixel(input in_item_t px);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned r;
    int unsigned c;
    int unsigned idx;
    pixel_t      up;
    pixel_t      lo;
    out_item_t   res;
    w_eff = clamp_dim(width_cfg, MAX_WIDTH);
    h_eff = clamp_dim(height_cfg, MAX_HEIGHT);
    if (px.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    up = row_above2[idx];
    lo = row_above1[idx];
    row_above2[idx] = lo;
    row_above1[idx] = px.pixel_value;
    // newest column enters on the right of each window row
    for (int k = 0; k < 3; k++) begin
      window[3 * k]     = window[3 * k + 1];
      window[3 * k + 1] = window[3 * k + 2];
    end
    window[2] = up;
    window[5] = lo;
    window[8] = px.pixel_value;
    if (r >= 1 && c >= 1) begin
      res.filtered_value = (r >= 2 && c >= 2) ? median_of_nine(window) : '0;
      res.out_row        = POS_BITS'(r - 1);
      res.out_col        = POS_BITS'(c - 1);
      res.frame_end      = (r + 1 == h_eff) && (c + 1 == w_eff);
      medians_due = {medians_due, res};
    end
    c++;
    if (c >= w_eff) begin
      c = 0;
      r++;
      if (r >= h_eff) r = 0;
    end
    col_pos = c % (1 << POS_BITS);
    row_pos = r % (1 << POS_BITS);
  endtask

  // sampled on the falling edge, where every signal holds its value for the next rise
  always @(negedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      for (int i = 0; i < WIN_TAPS; i++) window[i] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_cfg  = WIDTH_RESET;
      height_cfg = HEIGHT_RESET;
      medians_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_cfg = cfg_data;
          REG_FRAME_HEIGHT: height_cfg = cfg_data;
        endcase
      end
      // results first, so a result never meets an expectation from the same edge
      if (out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          $display("%0t: no result expected, actual value %0d row %0d col %0d end %0b",
                   $time, out_data.filtered_value, out_data.out_row, out_data.out_col,
                   out_data.frame_end);
          fail_count++;
        end else begin
          due = medians_due.pop_front();
          bad = 1'b0;
          if (out_data.filtered_value !== due.filtered_value) begin
            $display("%0t: filtered_value expected %0d actual %0d",
                     $time, due.filtered_value, out_data.filtered_value);
            bad = 1'b1;
          end
          if (out_data.out_row !== due.out_row) begin
            $display("%0t: out_row expected %0d actual %0d",
                     $time, due.out_row, out_data.out_row);
            bad = 1'b1;
          end
          if (out_data.out_col !== due.out_col) begin
            $display("%0t: out_col expected %0d actual %0d",
                     $time, due.out_col, out_data.out_col);
            bad = 1'b1;
          end
          if (out_data.frame_end !== due.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, due.frame_end, out_data.frame_end);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
      if (in_valid && !in_stall) filter_pixel(in_data);
    end
    results_pending = medians_due.size();
  end

endmodule

// File: sim/median_filter_3x3_unit_tb.sv
// testbench top for the 3x3 median filter: drives pixel streams and gives the verdict
`timescale 1ns / 1ps

module median_filter_3x3_unit_tb import mf3_pkg::*;;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  // quiet cycles tolerated before the run is declared hung
  localparam int LIMIT         = 2000;
  // long receiver hold-off, far longer than the job queue can absorb
  localparam int HOLD_CYCLES   = 200;
  // cycles allowed for work still in flight once the last result is in
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 32;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // directed stream on a 3x3 frame: a frame of extremes, a second frame
  // that begins by wrap-around alone, then a frame restarted after its first row
  localparam pixel_t DIR_PIX [25] = '{
    -32768, 32767, 0, -1, 32767, -32768, 1, -32768, 32767,
    32767, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767,
    5, 5, -5, 7, 3, 2, 1
  };
  localparam bit DIR_START [25] = '{
    1, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 1, 0, 0, 0
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  cfg_reg_t            cfg_index = REG_FRAME_WIDTH;
  logic [DIM_BITS-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;

  int fail_count;
  int results_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_served    = 0;
  int idle_cycles;

  always #1 clk = ~clk;

  median_filter_3x3_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  median_filter_3x3_unit_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // pixel mix: extremes, a narrow band that makes ties, and full-range noise
  function automatic pixel_t random_pixel();
    case ($urandom_range(9))
      0:       return {1'b1, {(PIXEL_BITS - 1){1'b0}}};
      1:       return {1'b0, {(PIXEL_BITS - 1){1'b1}}};
      2:       return pixel_t'(int'($urandom_range(8)) - 4);
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // mostly small frames, some below the minimum, some a bit wider
  function automatic logic [DIM_BITS-1:0] random_dim();
    case ($urandom_range(19))
      0, 1, 2: return DIM_BITS'($urandom_range(2));
      3, 4, 5: return DIM_BITS'($urandom_range(40, 11));
      default: return DIM_BITS'($urandom_range(10, 3));
    endcase
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      IDLE_BOTH:     begin send_idle_pct = 6;  recv_stall_pct = 6;  end
    endcase
  endtask

  // one pixel request; returns at the rising edge that accepts it
  task automatic send_pixel(input pixel_t value, input logic start);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {value, start};
    // stall is read on the falling edge, where it is settled for the next rise
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // stop offering pixels and wait until every predicted result is out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // geometry is only touched while the filter is empty
  task automatic configure(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // a phase: new geometry, then a raster stream that starts with frame_start,
  // mostly whole frames, sometimes chained by wrap-around, with a few early restarts
  task automatic run_phase(input logic [DIM_BITS-1:0] cfg_w, input logic [DIM_BITS-1:0] cfg_h,
                           input int n_items, input idle_mode_t mode,
                           input bit ask_hold, input bit ask_pause);
    int   w_eff;
    int   h_eff;
    int   pos;
    logic start;
    configure(cfg_w, cfg_h);
    set_idling(mode);
    w_eff = (cfg_w < DIM_MIN) ? DIM_MIN : ((cfg_w > MAX_W) ? MAX_W : cfg_w);
    h_eff = (cfg_h < DIM_MIN) ? DIM_MIN : ((cfg_h > MAX_H) ? MAX_H : cfg_h);
    pos = 0;
    for (int i = 0; i < n_items; i++) begin
      // receiver holds off while the sender keeps pushing, so the input stalls
      if (ask_hold && i == n_items / 2) hold_asks++;
      // sender waits for the pipeline to empty in mid-stream
      if (ask_pause && i == n_items / 3) drain_outputs();
      start = (i == 0) || (pos == 0 && $urandom_range(1) == 1) || ($urandom_range(99) < 3);
      if (start) pos = 0;
      send_pixel(random_pixel(), start);
      pos++;
      if (pos >= w_eff * h_eff) pos = 0;
    end
  endtask

  // receiver side: random stall per cycle, or a long counted hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: too many cycles with neither request nor result moving
  initial begin
    idle_cycles = 0;
    while (idle_cycles < LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("median_filter_3x3_unit test failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset geometry 640x480: well short of the first row, so no result is due
    set_idling(IDLE_RECEIVER);
    for (int i = 0; i < 20; i++) send_pixel(random_pixel(), i == 0);

    // directed: smallest frame, extreme pixels, wrap and restart after one row
    configure(DIM_MIN, DIM_MIN);
    set_idling(IDLE_NONE);
    for (int i = 0; i < 25; i++) send_pixel(DIR_PIX[i], DIR_START[i]);

    // register values below the minimum clamp to 3
    run_phase('0, DIM_BITS'(2), 40, IDLE_BOTH, 1'b0, 1'b0);
    // all-ones width clamps to the widest line, so a short stream stays on row 0
    run_phase('1, '0, 30, IDLE_BOTH, 1'b0, 1'b0);
    // narrowest frame with the tallest height, rows count on without wrapping
    run_phase(DIM_MIN, '1, 60, IDLE_SENDER, 1'b0, 1'b0);

    // random geometries under every idling pattern
    for (int k = 0; k < 6; k++) begin
      run_phase(random_dim(), random_dim(), $urandom_range(55, 35),
                idle_mode_t'(k % 4), k == 0, k == 1);
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("median_filter_3x3_unit test passed");
    end else begin
      $display("median_filter_3x3_unit test failed");
    end
    $finish;
  end

endmodule
